// ===== rtl/core/serial_adc_scan_master_macros.svh =====
// Assertion macros used by the checker file of the serial ADC scan master.
`ifndef SERIAL_ADC_SCAN_MASTER_MACROS_SVH
`define SERIAL_ADC_SCAN_MASTER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SADC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SADC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/sadc_pkg.sv =====
// Package with types, constants and codes of the serial ADC scan master.
`timescale 1ns / 1ps
`default_nettype none
package sadc_pkg;

    localparam int CHANNELS   = 4;
    localparam int DATA_BITS  = 8;
    localparam int LAST_PHASE = 9 + 2 * DATA_BITS;
    localparam int PHASE_W    = $clog2(LAST_PHASE + 1);
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [PHASE_W-1:0] t_phase;

    localparam logic [1:0] OP_STROBE = 2'd0;
    localparam logic [1:0] OP_SCAN   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_FIRST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_SECOND  = 2'd3;

    localparam logic [15:0] TICK_PERIOD_RST = 16'd100;
    localparam logic [1:0]  CHAN_FIRST_RST  = 2'd0;
    localparam logic [1:0]  CHAN_SECOND_RST = 2'd1;

    // Channel count widened so that it compares against any 2-bit channel.
    localparam logic [2:0] NUM_CH = 3'(CHANNELS);

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] channel;
        logic       dout_pin;
    } t_in;

    typedef struct packed {
        logic       cs_n;
        logic       sclk;
        logic       din;
        logic       busy_res;
        logic       done_res;
        logic [1:0] done_channel;
        logic [7:0] done_value;
        logic [7:0] read_value;
        logic       rejected;
    } t_out;

    typedef struct packed {
        logic       cs_n;
        logic       sclk;
        logic       din;
        logic       busy;
        logic       done;
        logic [1:0] done_channel;
        logic [7:0] done_value;
        logic       rejected;
    } t_seq_stat;

    typedef struct packed {
        logic       en;
        logic [1:0] channel;
        logic [7:0] data;
    } t_cache_wr;

endpackage
`default_nettype wire

// ===== rtl/core/sadc_tick.sv =====
// Tick counter that fires the periodic scan request.
`timescale 1ns / 1ps
`default_nettype none
module sadc_tick
    import sadc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [1:0]  i_opcode,
    input  wire logic        i_enable,
    input  wire logic [15:0] i_period,
    output logic             o_tick_fire
);

    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [15:0] inc;

    always_comb begin
        inc         = r_count + 16'd1;
        n_count     = r_count;
        o_tick_fire = 1'b0;
        if (i_fire && (i_opcode == OP_TICK) && i_enable) begin
            if (inc == i_period) begin
                n_count     = '0;
                o_tick_fire = 1'b1;
            end else begin
                n_count = inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sadc_cache.sv =====
// Per-channel cache of the last converted byte.
`timescale 1ns / 1ps
`default_nettype none
module sadc_cache
    import sadc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cache_wr  i_wr,
    input  wire logic       i_rd_en,
    input  wire logic [1:0] i_rd_channel,
    output logic [7:0]      o_rd_value
);

    logic [7:0] r_cache [CHANNELS];
    logic       wr_hit;
    logic       rd_hit;

    assign wr_hit = i_wr.en && ({1'b0, i_wr.channel} < NUM_CH);
    assign rd_hit = i_rd_en && ({1'b0, i_rd_channel} < NUM_CH);
    assign o_rd_value = rd_hit ? r_cache[i_rd_channel[CH_IDX_W-1:0]] : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_cache[i] <= '0;
            end
        end else if (wr_hit) begin
            r_cache[i_wr.channel[CH_IDX_W-1:0]] <= i_wr.data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sadc_sequencer.sv =====
// Pin sequencer: chip select, clock and data pins, shift register and scan queue.
`timescale 1ns / 1ps
`default_nettype none
module sadc_sequencer
    import sadc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire t_in        i_item,
    input  wire logic       i_tick_fire,
    input  wire logic [1:0] i_chan_first,
    input  wire logic [1:0] i_chan_second,
    output t_seq_stat       o_stat,
    output t_cache_wr       o_cache_wr
);

    localparam t_phase PH_ONE        = PHASE_W'(1);
    localparam t_phase PH_SE_BIT     = PHASE_W'(2);
    localparam t_phase PH_CH0_BIT    = PHASE_W'(4);
    localparam t_phase PH_CH1_BIT    = PHASE_W'(6);
    localparam t_phase PH_HDR_LAST   = PHASE_W'(8);
    localparam t_phase PH_DATA_FIRST = PHASE_W'(10);
    localparam t_phase PH_LAST       = PHASE_W'(LAST_PHASE);

    t_phase     r_phase,  n_phase;
    logic [1:0] r_chan,   n_chan;
    logic [7:0] r_shift,  n_shift;
    logic       r_pend_first, n_pend_first;
    logic       r_pend_second, n_pend_second;
    logic       r_cs_n,   n_cs_n;
    logic       r_sclk,   n_sclk;
    logic       r_din,    n_din;

    logic       start_en;
    logic [1:0] start_ch;
    logic       done;
    logic       rejected;

    always_comb begin
        n_phase       = r_phase;
        n_chan        = r_chan;
        n_shift       = r_shift;
        n_pend_first  = r_pend_first;
        n_pend_second = r_pend_second;
        n_cs_n        = r_cs_n;
        n_sclk        = r_sclk;
        n_din         = r_din;
        start_en      = 1'b0;
        start_ch      = '0;
        done          = 1'b0;
        rejected      = 1'b0;

        if (i_fire) begin
            unique case (i_item.opcode)
                OP_STROBE: begin
                    if (r_phase == '0) begin
                        priority if (r_pend_first) begin
                            n_pend_first = 1'b0;
                            start_en     = 1'b1;
                            start_ch     = i_chan_first;
                        end else if (r_pend_second) begin
                            n_pend_second = 1'b0;
                            start_en      = 1'b1;
                            start_ch      = i_chan_second;
                        end else begin
                        end
                    end else begin
                        if (r_phase <= PH_HDR_LAST) begin
                            if (r_phase[0]) begin
                                n_sclk = 1'b1;
                            end else begin
                                n_sclk = 1'b0;
                                priority if (r_phase == PH_SE_BIT) begin
                                    n_din = 1'b1;
                                end else if (r_phase == PH_CH0_BIT) begin
                                    n_din = r_chan[0];
                                end else if (r_phase == PH_CH1_BIT) begin
                                    n_din = r_chan[1];
                                end else begin
                                end
                            end
                        end else if (r_phase >= PH_DATA_FIRST) begin
                            if (!r_phase[0]) begin
                                n_sclk = 1'b1;
                            end else begin
                                n_sclk  = 1'b0;
                                n_shift = {r_shift[6:0], i_item.dout_pin};
                            end
                        end
                        if (r_phase >= PH_LAST) begin
                            n_cs_n  = 1'b1;
                            done    = 1'b1;
                            n_phase = '0;
                        end else begin
                            n_phase = r_phase + PH_ONE;
                        end
                    end
                end
                OP_SCAN: begin
                    if (r_phase != '0) begin
                        rejected = 1'b1;
                    end else begin
                        start_en = 1'b1;
                        start_ch = i_item.channel;
                    end
                end
                OP_READ: begin
                end
                OP_TICK: begin
                    if (i_tick_fire) begin
                        n_pend_first  = 1'b1;
                        n_pend_second = 1'b1;
                    end
                end
            endcase
        end

        if (start_en) begin
            n_chan  = start_ch;
            n_shift = '0;
            n_phase = PH_ONE;
            n_cs_n  = 1'b0;
            n_din   = 1'b1;
            n_sclk  = 1'b0;
        end
    end

    always_comb begin
        o_stat.cs_n         = n_cs_n;
        o_stat.sclk         = n_sclk;
        o_stat.din          = n_din;
        o_stat.busy         = (n_phase != '0);
        o_stat.done         = done;
        o_stat.done_channel = done ? r_chan : 2'd0;
        o_stat.done_value   = done ? n_shift : 8'd0;
        o_stat.rejected     = rejected;
        o_cache_wr.en       = done;
        o_cache_wr.channel  = r_chan;
        o_cache_wr.data     = n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_chan        <= '0;
            r_shift       <= '0;
            r_pend_first  <= 1'b0;
            r_pend_second <= 1'b0;
            r_cs_n        <= 1'b1;
            r_sclk        <= 1'b0;
            r_din         <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_chan        <= n_chan;
            r_shift       <= n_shift;
            r_pend_first  <= n_pend_first;
            r_pend_second <= n_pend_second;
            r_cs_n        <= n_cs_n;
            r_sclk        <= n_sclk;
            r_din         <= n_din;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/serial_adc_scan_master.sv =====
// Top level of the serial ADC scan master: handshakes, registers and result stage.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one item per cycle:
// when ready: a half-bit strobe, a scan request, a cache read or a system tick.
// Every accepted item yields exactly one result on the output channel
// (o_out_valid / i_out_ready / o_out_data), offered from the cycle after acceptance.
// Unstalled throughput is one item per cycle; the sequencer, tick counter and
// cache all update in the accepting cycle and the result sits in a single output
// register. When the receiver stalls, the result is held and o_in_ready stays high
// only while that register can be emptied in the same cycle, so nothing is dropped.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is always
// ready: 0 tick period, 1 periodic enable, 2 first channel, 3 second channel.
// Reset is synchronous, active low: the cache reads zero, the sequencer is idle,
// cs_n is high, sclk and din low, no scans are pending, the tick count is zero,
// the registers take their defaults and the output register is empty.
`timescale 1ns / 1ps
`default_nettype none
module serial_adc_scan_master
    import sadc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_tick_period;
    logic        r_periodic_en;
    logic [1:0]  r_chan_first;
    logic [1:0]  r_chan_second;

    logic        r_out_valid;
    t_out        r_out_data;
    t_out        n_out_data;

    logic        in_fire;
    logic        cfg_fire;
    logic        tick_fire;
    t_seq_stat   stat;
    t_cache_wr   cache_wr;
    logic [7:0]  rd_value;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RST;
            r_periodic_en <= 1'b1;
            r_chan_first  <= CHAN_FIRST_RST;
            r_chan_second <= CHAN_SECOND_RST;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_TICK_PERIOD: r_tick_period <= i_cfg_data;
                REG_PERIODIC_EN: r_periodic_en <= i_cfg_data[0];
                REG_CHAN_FIRST:  r_chan_first  <= i_cfg_data[1:0];
                REG_CHAN_SECOND: r_chan_second <= i_cfg_data[1:0];
            endcase
        end
    end

    sadc_tick u_tick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_opcode    (i_in_data.opcode),
        .i_enable    (r_periodic_en),
        .i_period    (r_tick_period),
        .o_tick_fire (tick_fire)
    );

    sadc_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_item        (i_in_data),
        .i_tick_fire   (tick_fire),
        .i_chan_first  (r_chan_first),
        .i_chan_second (r_chan_second),
        .o_stat        (stat),
        .o_cache_wr    (cache_wr)
    );

    sadc_cache u_cache (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (cache_wr),
        .i_rd_en      (i_in_data.opcode == OP_READ),
        .i_rd_channel (i_in_data.channel),
        .o_rd_value   (rd_value)
    );

    always_comb begin
        n_out_data.cs_n         = stat.cs_n;
        n_out_data.sclk         = stat.sclk;
        n_out_data.din          = stat.din;
        n_out_data.busy_res     = stat.busy;
        n_out_data.done_res     = stat.done;
        n_out_data.done_channel = stat.done_channel;
        n_out_data.done_value   = stat.done_value;
        n_out_data.read_value   = rd_value;
        n_out_data.rejected     = stat.rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sadc_checker.sv =====
// Port-level checker for the serial ADC scan master, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_adc_scan_master_macros.svh"
module sadc_checker
    import sadc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic o_in_ready,
    input  wire logic o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_out o_out_data
);

    logic out_stall;
    logic out_done;
    logic out_idle;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_done  = o_out_valid && o_out_data.done_res;
    assign out_idle  = o_out_valid && !o_out_data.busy_res;

    `SADC_ASSERT(a_out_hold, out_stall |=> o_out_valid && $stable(o_out_data), "stalled item changed")
    `SADC_ASSERT(a_ready_when_empty, !o_out_valid |-> o_in_ready, "input stalled with empty output")
    `SADC_ASSERT(a_done_idle, out_done |-> o_out_data.cs_n && !o_out_data.busy_res, "done while selected")
    `SADC_ASSERT(a_idle_cs_high, out_idle |-> o_out_data.cs_n, "chip select low while idle")
    `SADC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind serial_adc_scan_master sadc_checker u_sadc_checker (.*);
`default_nettype wire
